/* sv/brm_pkg.sv */
// Block relocation map: shared types, codes and constants.
// Used by every module of the block but brm_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package brm_pkg;

    localparam int ZONE_W    = 16;
    localparam int ZONE_SPAN = 65536;
    localparam int LIMIT_W   = 17;
    localparam int O2N_W     = ZONE_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_START      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_ZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY_MODE  = 3'd3;

    localparam logic [ZONE_W-1:0]  FILL_START_RST      = 16'd1;
    localparam logic [ZONE_W-1:0]  FIRST_DATA_ZONE_RST = 16'd0;
    localparam logic [LIMIT_W-1:0] ZONE_LIMIT_RST      = 17'd65536;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_RELOC = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FIXED   = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NO_DEST = 2'd3;

    typedef struct packed {
        logic [ZONE_W-1:0]  fill_start;
        logic [ZONE_W-1:0]  first_data_zone;
        logic [LIMIT_W-1:0] zone_limit;
        logic               read_only_mode;
    } t_cfg;

    typedef struct packed {
        logic              load;
        logic [ZONE_W-1:0] value;
    } t_fp_load;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DISPATCH = 8'b0000_0100,
        S_SKIP_RD  = 8'b0000_1000,
        S_SKIP_CHK = 8'b0001_0000,
        S_SWAP_A   = 8'b0010_0000,
        S_SWAP_B   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    function automatic int map_depth(input int num_zones);
        return (num_zones < ZONE_SPAN) ? num_zones : ZONE_SPAN;
    endfunction

endpackage
`default_nettype wire

/* sv/block_relocation_map_unit.sv */
// Block relocation map, top level: config registers, sequencer, two map RAMs.
// Depends on brm_pkg, brm_cfg, brm_ctrl and brm_ram.
//
// Usage:
//   Request channel (i_req_valid / o_req_ready) carries func, zone, in_use and
//   is_fixed; response channel (o_rsp_valid / i_rsp_ready) carries new_zone,
//   back_zone and status, one response per request, in order.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at the clock
//   edge; issue them only while no request is in flight.
//   One request is in the sequencer at a time; the next is accepted once it
//   is idle again. Load, read, rejected requests: dispatch, done. Relocate:
//   dispatch, a read and a check at the fill pointer (again per fixed zone
//   skipped), the swap steps, done; or done early if no destination is left.
//   The fixed-zone walk and the single old-to-new RAM read port set the steps.
//   Reset starts a clearing pass over the old-to-new RAM (it also holds the
//   fixed bits), one entry per cycle, MAP_DEPTH entries (65536 by default);
//   o_req_ready stays low until it ends. Config writes are taken throughout.
//   A response waiting on a stalled receiver sits in the output register; the
//   next request is accepted and worked on meanwhile, and its response waits
//   in the sequencer until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module block_relocation_map_unit #(
    parameter int NUM_ZONES = 65536
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [brm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [brm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire logic [1:0]                     i_func,
    input  wire logic [brm_pkg::ZONE_W-1:0]     i_zone,
    input  wire logic                           i_in_use,
    input  wire logic                           i_is_fixed,
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output logic      [brm_pkg::ZONE_W-1:0]     o_new_zone,
    output logic      [brm_pkg::ZONE_W-1:0]     o_back_zone,
    output logic      [1:0]                     o_status
);

    localparam int MAP_DEPTH = brm_pkg::map_depth(NUM_ZONES);
    localparam int AW        = $clog2(MAP_DEPTH);

    brm_pkg::t_cfg     w_cfg;
    brm_pkg::t_fp_load w_fp_load;

    logic                        w_o2n_we;
    logic [AW-1:0]               w_o2n_waddr;
    logic [brm_pkg::O2N_W-1:0]   w_o2n_wdata;
    logic [AW-1:0]               w_o2n_raddr;
    logic [brm_pkg::O2N_W-1:0]   w_o2n_rdata;
    logic                        w_n2o_we;
    logic [AW-1:0]               w_n2o_waddr;
    logic [brm_pkg::ZONE_W-1:0]  w_n2o_wdata;
    logic [AW-1:0]               w_n2o_raddr;
    logic [brm_pkg::ZONE_W-1:0]  w_n2o_rdata;

    brm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_fp_load  (w_fp_load)
    );

    brm_ctrl #(
        .NUM_ZONES (NUM_ZONES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fp_load   (w_fp_load),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_func      (i_func),
        .i_zone      (i_zone),
        .i_in_use    (i_in_use),
        .i_is_fixed  (i_is_fixed),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_new_zone  (o_new_zone),
        .o_back_zone (o_back_zone),
        .o_status    (o_status),
        .o_o2n_we    (w_o2n_we),
        .o_o2n_waddr (w_o2n_waddr),
        .o_o2n_wdata (w_o2n_wdata),
        .o_o2n_raddr (w_o2n_raddr),
        .i_o2n_rdata (w_o2n_rdata),
        .o_n2o_we    (w_n2o_we),
        .o_n2o_waddr (w_n2o_waddr),
        .o_n2o_wdata (w_n2o_wdata),
        .o_n2o_raddr (w_n2o_raddr),
        .i_n2o_rdata (w_n2o_rdata)
    );

    brm_ram #(
        .WIDTH (brm_pkg::O2N_W),
        .DEPTH (MAP_DEPTH)
    ) u_o2n_ram (
        .i_clk   (i_clk),
        .i_we    (w_o2n_we),
        .i_waddr (w_o2n_waddr),
        .i_wdata (w_o2n_wdata),
        .i_raddr (w_o2n_raddr),
        .o_rdata (w_o2n_rdata)
    );

    brm_ram #(
        .WIDTH (brm_pkg::ZONE_W),
        .DEPTH (MAP_DEPTH)
    ) u_n2o_ram (
        .i_clk   (i_clk),
        .i_we    (w_n2o_we),
        .i_waddr (w_n2o_waddr),
        .i_wdata (w_n2o_wdata),
        .i_raddr (w_n2o_raddr),
        .o_rdata (w_n2o_rdata)
    );

endmodule
`default_nettype wire

/* sv/brm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module brm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* sv/brm_cfg.sv */
// Configuration registers of the block relocation map.
// Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brm_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [brm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [brm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output brm_pkg::t_cfg                           o_cfg,
    output brm_pkg::t_fp_load                       o_fp_load
);

    brm_pkg::t_cfg r_cfg;
    brm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        o_fp_load.load  = 1'b0;
        o_fp_load.value = i_cfg_data[brm_pkg::ZONE_W-1:0];
        if (i_cfg_we) begin
            case (i_cfg_idx)
                brm_pkg::CFG_FILL_START: begin
                    n_cfg.fill_start = i_cfg_data[brm_pkg::ZONE_W-1:0];
                    o_fp_load.load   = 1'b1;
                end
                brm_pkg::CFG_FIRST_DATA_ZONE: begin
                    n_cfg.first_data_zone = i_cfg_data[brm_pkg::ZONE_W-1:0];
                end
                brm_pkg::CFG_ZONE_LIMIT: begin
                    n_cfg.zone_limit = i_cfg_data;
                end
                brm_pkg::CFG_READ_ONLY_MODE: begin
                    n_cfg.read_only_mode = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fill_start      <= brm_pkg::FILL_START_RST;
            r_cfg.first_data_zone <= brm_pkg::FIRST_DATA_ZONE_RST;
            r_cfg.zone_limit      <= brm_pkg::ZONE_LIMIT_RST;
            r_cfg.read_only_mode  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* sv/brm_ctrl.sv */
// Sequencer of the block relocation map: read-modify-write on the two map RAMs,
// fixed-zone skip, clearing pass and response register. Depends on brm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brm_ctrl #(
    parameter int NUM_ZONES = 65536
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire brm_pkg::t_cfg                  i_cfg,
    input  wire brm_pkg::t_fp_load              i_fp_load,
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire logic [1:0]                     i_func,
    input  wire logic [brm_pkg::ZONE_W-1:0]     i_zone,
    input  wire logic                           i_in_use,
    input  wire logic                           i_is_fixed,
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output logic      [brm_pkg::ZONE_W-1:0]     o_new_zone,
    output logic      [brm_pkg::ZONE_W-1:0]     o_back_zone,
    output logic      [1:0]                     o_status,
    output logic                                o_o2n_we,
    output logic [$clog2(brm_pkg::map_depth(NUM_ZONES))-1:0] o_o2n_waddr,
    output logic      [brm_pkg::O2N_W-1:0]      o_o2n_wdata,
    output logic [$clog2(brm_pkg::map_depth(NUM_ZONES))-1:0] o_o2n_raddr,
    input  wire logic [brm_pkg::O2N_W-1:0]      i_o2n_rdata,
    output logic                                o_n2o_we,
    output logic [$clog2(brm_pkg::map_depth(NUM_ZONES))-1:0] o_n2o_waddr,
    output logic      [brm_pkg::ZONE_W-1:0]     o_n2o_wdata,
    output logic [$clog2(brm_pkg::map_depth(NUM_ZONES))-1:0] o_n2o_raddr,
    input  wire logic [brm_pkg::ZONE_W-1:0]     i_n2o_rdata
);

    localparam int MAP_DEPTH = brm_pkg::map_depth(NUM_ZONES);
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int ZW        = brm_pkg::ZONE_W;
    localparam int LW        = brm_pkg::LIMIT_W;
    localparam logic [LW-1:0] DEPTH_L  = LW'(MAP_DEPTH);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAP_DEPTH - 1);

    brm_pkg::t_state r_state, n_state;
    logic [1:0]    r_func, n_func;
    logic [ZW-1:0] r_zone, n_zone;
    logic          r_in_use, n_in_use;
    logic          r_is_fixed, n_is_fixed;
    logic [LW-1:0] r_fp, n_fp;
    logic [ZW-1:0] r_nx, n_nx;
    logic [ZW-1:0] r_dst, n_dst;
    logic [ZW-1:0] r_oy, n_oy;
    logic [AW-1:0] r_clr, n_clr;
    logic [ZW-1:0] r_nz, n_nz;
    logic [ZW-1:0] r_bz, n_bz;
    logic [1:0]    r_st, n_st;
    logic          r_rsp_valid, n_rsp_valid;
    logic [ZW-1:0] r_out_nz, n_out_nz;
    logic [ZW-1:0] r_out_bz, n_out_bz;
    logic [1:0]    r_out_st, n_out_st;

    logic [LW-1:0] w_end;
    logic [LW-1:0] w_zone_l;
    logic          w_zone_ok;
    logic          w_fp_ok;
    logic [ZW-1:0] w_load_val;
    logic          w_oy_fixed;

    assign w_end      = (i_cfg.zone_limit < DEPTH_L) ? i_cfg.zone_limit : DEPTH_L;
    assign w_zone_l   = {1'b0, r_zone};
    assign w_zone_ok  = (w_zone_l >= {1'b0, i_cfg.first_data_zone})
                        && (w_zone_l < i_cfg.zone_limit) && (w_zone_l < DEPTH_L);
    assign w_fp_ok    = (r_fp >= {1'b0, i_cfg.first_data_zone})
                        && (r_fp < i_cfg.zone_limit) && (r_fp < DEPTH_L);
    assign w_load_val = r_in_use ? r_zone : '0;
    assign w_oy_fixed = (r_oy == r_zone) ? 1'b0 : i_o2n_rdata[ZW];

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_zone      = r_zone;
        n_in_use    = r_in_use;
        n_is_fixed  = r_is_fixed;
        n_fp        = r_fp;
        n_nx        = r_nx;
        n_dst       = r_dst;
        n_oy        = r_oy;
        n_clr       = r_clr;
        n_nz        = r_nz;
        n_bz        = r_bz;
        n_st        = r_st;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_out_nz    = r_out_nz;
        n_out_bz    = r_out_bz;
        n_out_st    = r_out_st;
        o_o2n_we    = 1'b0;
        o_o2n_waddr = r_zone[AW-1:0];
        o_o2n_wdata = '0;
        o_o2n_raddr = r_zone[AW-1:0];
        o_n2o_we    = 1'b0;
        o_n2o_waddr = r_zone[AW-1:0];
        o_n2o_wdata = '0;
        o_n2o_raddr = r_zone[AW-1:0];

        case (r_state)
            brm_pkg::S_CLEAR: begin
                o_o2n_we    = 1'b1;
                o_o2n_waddr = r_clr;
                n_clr       = r_clr + AW'(1);
                if (r_clr == LAST_ADR) begin
                    n_state = brm_pkg::S_IDLE;
                end
            end
            brm_pkg::S_IDLE: begin
                o_o2n_raddr = i_zone[AW-1:0];
                o_n2o_raddr = i_zone[AW-1:0];
                if (i_req_valid) begin
                    n_func     = i_func;
                    n_zone     = i_zone;
                    n_in_use   = i_in_use;
                    n_is_fixed = i_is_fixed;
                    n_state    = brm_pkg::S_DISPATCH;
                end
            end
            brm_pkg::S_DISPATCH: begin
                n_nz    = '0;
                n_bz    = '0;
                n_st    = brm_pkg::ST_DONE;
                n_state = brm_pkg::S_DONE;
                case (r_func)
                    brm_pkg::FUNC_LOAD: begin
                        if (!w_zone_ok) begin
                            n_st = brm_pkg::ST_RANGE;
                        end else begin
                            o_o2n_we    = 1'b1;
                            o_o2n_wdata = {r_is_fixed, w_load_val};
                            o_n2o_we    = 1'b1;
                            o_n2o_wdata = w_load_val;
                        end
                    end
                    brm_pkg::FUNC_RELOC: begin
                        n_nz = r_zone;
                        if (!w_zone_ok) begin
                            n_st = brm_pkg::ST_RANGE;
                        end else if (i_o2n_rdata[ZW]) begin
                            n_st = brm_pkg::ST_FIXED;
                        end else begin
                            n_nx    = i_o2n_rdata[ZW-1:0];
                            n_state = brm_pkg::S_SKIP_RD;
                        end
                    end
                    brm_pkg::FUNC_READ: begin
                        if (!w_zone_ok) begin
                            n_st = brm_pkg::ST_RANGE;
                        end else begin
                            n_nz = i_o2n_rdata[ZW-1:0];
                            n_bz = i_n2o_rdata;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            brm_pkg::S_SKIP_RD: begin
                o_o2n_raddr = r_fp[AW-1:0];
                if (r_fp < w_end) begin
                    n_state = brm_pkg::S_SKIP_CHK;
                end else begin
                    n_st    = brm_pkg::ST_NO_DEST;
                    n_state = brm_pkg::S_DONE;
                end
            end
            brm_pkg::S_SKIP_CHK: begin
                o_n2o_raddr = r_fp[AW-1:0];
                if (i_o2n_rdata[ZW]) begin
                    n_fp    = r_fp + LW'(1);
                    n_state = brm_pkg::S_SKIP_RD;
                end else if (!w_fp_ok) begin
                    n_st    = brm_pkg::ST_NO_DEST;
                    n_state = brm_pkg::S_DONE;
                end else begin
                    n_dst   = r_fp[ZW-1:0];
                    n_fp    = r_fp + LW'(1);
                    n_state = brm_pkg::S_SWAP_A;
                end
            end
            brm_pkg::S_SWAP_A: begin
                n_oy        = i_n2o_rdata;
                o_o2n_we    = 1'b1;
                o_o2n_wdata = {1'b0, r_dst};
                o_o2n_raddr = i_n2o_rdata[AW-1:0];
                o_n2o_we    = ({1'b0, r_nx} < DEPTH_L);
                o_n2o_waddr = r_nx[AW-1:0];
                o_n2o_wdata = i_n2o_rdata;
                n_state     = brm_pkg::S_SWAP_B;
            end
            brm_pkg::S_SWAP_B: begin
                o_o2n_we    = (r_oy != '0) && ({1'b0, r_oy} < DEPTH_L);
                o_o2n_waddr = r_oy[AW-1:0];
                o_o2n_wdata = {w_oy_fixed, r_nx};
                o_n2o_we    = 1'b1;
                o_n2o_waddr = r_dst[AW-1:0];
                o_n2o_wdata = r_zone;
                n_nz        = i_cfg.read_only_mode ? r_zone : r_dst;
                n_st        = brm_pkg::ST_DONE;
                n_state     = brm_pkg::S_DONE;
            end
            brm_pkg::S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid = 1'b1;
                    n_out_nz    = r_nz;
                    n_out_bz    = r_bz;
                    n_out_st    = r_st;
                    n_state     = brm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brm_pkg::S_IDLE;
            end
        endcase

        if (i_fp_load.load) begin
            n_fp = {1'b0, i_fp_load.value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brm_pkg::S_CLEAR;
            r_clr       <= '0;
            r_fp        <= {1'b0, brm_pkg::FILL_START_RST};
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_fp        <= n_fp;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_zone     <= n_zone;
        r_in_use   <= n_in_use;
        r_is_fixed <= n_is_fixed;
        r_nx       <= n_nx;
        r_dst      <= n_dst;
        r_oy       <= n_oy;
        r_nz       <= n_nz;
        r_bz       <= n_bz;
        r_st       <= n_st;
        r_out_nz   <= n_out_nz;
        r_out_bz   <= n_out_bz;
        r_out_st   <= n_out_st;
    end

    assign o_req_ready = (r_state == brm_pkg::S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_new_zone  = r_out_nz;
    assign o_back_zone = r_out_bz;
    assign o_status    = r_out_st;

endmodule
`default_nettype wire

/* sv/brm_chk.sv */
// Port-level checker for the block relocation map, bound to the top level.
// Depends on brm_pkg and block_relocation_map_unit.
`timescale 1ns / 1ps
`default_nettype none
module brm_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       o_req_ready,
    input wire logic                       o_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic [brm_pkg::ZONE_W-1:0] o_new_zone,
    input wire logic [brm_pkg::ZONE_W-1:0] o_back_zone,
    input wire logic [1:0]                 o_status
);

    a_reset_clears_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=>
            o_rsp_valid && $stable(o_new_zone) && $stable(o_back_zone) && $stable(o_status))
        else $error("stalled response changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in flight");

    a_back_zone_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status != brm_pkg::ST_DONE) |-> (o_back_zone == '0))
        else $error("back zone set on a failed request");

endmodule

bind block_relocation_map_unit brm_chk u_brm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_new_zone  (o_new_zone),
    .o_back_zone (o_back_zone),
    .o_status    (o_status)
);
`default_nettype wire

/* bench/brm_map_checker.sv */
// Scoreboard for the block relocation map: mirrors both zone maps, the fixed
// bits, the fill pointer and the config registers from the observed ports.
// Depends on brm_pkg only.
`timescale 1ns / 1ps
module brm_map_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [brm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [brm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_req_valid,
    input  wire logic                           i_req_ready,
    input  wire logic [1:0]                     i_func,
    input  wire logic [brm_pkg::ZONE_W-1:0]     i_zone,
    input  wire logic                           i_in_use,
    input  wire logic                           i_is_fixed,
    input  wire logic                           i_rsp_valid,
    input  wire logic                           i_rsp_ready,
    input  wire logic [brm_pkg::ZONE_W-1:0]     i_new_zone,
    input  wire logic [brm_pkg::ZONE_W-1:0]     i_back_zone,
    input  wire logic [1:0]                     i_status,
    output int                                  o_errors,
    output int                                  o_pending,
    output logic [3:0][31:0]                    o_status_count
);
    import brm_pkg::*;

    typedef struct packed {
        logic [ZONE_W-1:0] new_zone;
        logic [ZONE_W-1:0] back_zone;
        logic [1:0]        status;
    } zone_answer_t;

    logic [ZONE_W-1:0]  fwd_map [ZONE_SPAN];
    logic [ZONE_W-1:0]  rev_map [ZONE_SPAN];
    bit                 pinned  [ZONE_SPAN];
    logic [LIMIT_W-1:0] fill_ptr;
    t_cfg               cfg;
    zone_answer_t       answer_q [$];
    zone_answer_t       got;
    zone_answer_t       want;
    int                 mismatches = 0;
    logic [3:0][31:0]   status_seen = '0;

    assign o_errors       = mismatches;
    assign o_status_count = status_seen;

    task automatic report_mismatch(input string what, input int exp_val, input int seen);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_val, seen);
        mismatches++;
    endtask

    function automatic bit zone_ok(input int unsigned z);
        return z >= cfg.first_data_zone && z < cfg.zone_limit && z < ZONE_SPAN;
    endfunction

    function automatic zone_answer_t apply_request(
        input logic [1:0]        func,
        input logic [ZONE_W-1:0] zone,
        input logic              in_use,
        input logic              is_fixed
    );
        zone_answer_t      ans;
        int unsigned       stop;
        int unsigned       dst;
        logic [ZONE_W-1:0] nx;
        logic [ZONE_W-1:0] oy;
        ans = '0;
        case (func)
            FUNC_LOAD: begin
                if (!zone_ok(zone)) begin
                    ans.status = ST_RANGE;
                end else begin
                    fwd_map[zone] = in_use ? zone : '0;
                    rev_map[zone] = in_use ? zone : '0;
                    pinned[zone]  = is_fixed;
                end
            end
            FUNC_RELOC: begin
                ans.new_zone = zone;
                if (!zone_ok(zone)) begin
                    ans.status = ST_RANGE;
                end else if (pinned[zone]) begin
                    ans.status = ST_FIXED;
                end else begin
                    stop = (cfg.zone_limit < ZONE_SPAN) ? cfg.zone_limit : ZONE_SPAN;
                    // skip unmovable zones ahead of the fill pointer
                    while (fill_ptr < stop && pinned[fill_ptr[ZONE_W-1:0]])
                        fill_ptr = fill_ptr + 1'b1;
                    dst = fill_ptr;
                    if (!zone_ok(dst)) begin
                        ans.status = ST_NO_DEST;
                    end else begin
                        fill_ptr = fill_ptr + 1'b1;
                        nx = fwd_map[zone];
                        oy = rev_map[dst];
                        fwd_map[zone] = dst[ZONE_W-1:0];
                        if (oy != '0)
                            fwd_map[oy] = nx;
                        rev_map[nx]  = oy;
                        rev_map[dst] = zone;
                        if (!cfg.read_only_mode)
                            ans.new_zone = dst[ZONE_W-1:0];
                    end
                end
            end
            FUNC_READ: begin
                if (!zone_ok(zone)) begin
                    ans.status = ST_RANGE;
                end else begin
                    ans.new_zone  = fwd_map[zone];
                    ans.back_zone = rev_map[zone];
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ZONE_SPAN; i++)
                pinned[i] = 1'b0;
            cfg      = '{FILL_START_RST, FIRST_DATA_ZONE_RST, ZONE_LIMIT_RST, 1'b0};
            fill_ptr = {1'b0, FILL_START_RST};
            answer_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FILL_START: begin
                        cfg.fill_start = i_cfg_data[ZONE_W-1:0];
                        fill_ptr       = {1'b0, cfg.fill_start};
                    end
                    CFG_FIRST_DATA_ZONE: cfg.first_data_zone = i_cfg_data[ZONE_W-1:0];
                    CFG_ZONE_LIMIT:      cfg.zone_limit      = i_cfg_data;
                    CFG_READ_ONLY_MODE:  cfg.read_only_mode  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = {i_new_zone, i_back_zone, i_status};
                status_seen[i_status] = status_seen[i_status] + 1;
                if (answer_q.size() == 0) begin
                    report_mismatch("response with nothing pending, status", -1, got.status);
                end else begin
                    want = answer_q.pop_front();
                    if (got.new_zone !== want.new_zone)
                        report_mismatch("new_zone", want.new_zone, got.new_zone);
                    if (got.back_zone !== want.back_zone)
                        report_mismatch("back_zone", want.back_zone, got.back_zone);
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                end
            end
            if (i_req_valid && i_req_ready)
                answer_q.push_back(apply_request(i_func, i_zone, i_in_use, i_is_fixed));
        end
        o_pending <= answer_q.size();
    end

endmodule

/* bench/tb_block_relocation_map_unit.sv */
// Top of the relocation map bench: clock, reset, config phases, request
// traffic with random gaps on both channels, watchdog and verdict.
// Depends on brm_pkg, block_relocation_map_unit and brm_map_checker.
`timescale 1ns / 1ps
module tb_block_relocation_map_unit;
    import brm_pkg::*;

    localparam logic [1:0]           FUNC_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX   = 3'd7;
    localparam int                   WATCHDOG_LIMIT  = 300000;
    localparam int                   MAX_GAP         = 11;
    localparam int                   HOLD_CYCLES     = 200;
    localparam int                   TAIL_CYCLES     = 32;
    localparam int                   RANDOM_PHASES   = 12;
    localparam int                   ITEMS_PER_PHASE = 56;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [1:0]            func      = FUNC_LOAD;
    logic [ZONE_W-1:0]     zone      = '0;
    logic                  in_use    = 1'b0;
    logic                  is_fixed  = 1'b0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    logic [ZONE_W-1:0]     new_zone;
    logic [ZONE_W-1:0]     back_zone;
    logic [1:0]            status;

    int                    errors;
    int                    pending;
    logic [3:0][31:0]      status_count;
    int                    sent_count   = 0;
    int                    phase_count  = 0;
    bit                    quiet        = 1'b0;
    bit                    hold_request = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    block_relocation_map_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_func      (func),
        .i_zone      (zone),
        .i_in_use    (in_use),
        .i_is_fixed  (is_fixed),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_new_zone  (new_zone),
        .o_back_zone (back_zone),
        .o_status    (status)
    );

    brm_map_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_req_valid    (req_valid),
        .i_req_ready    (req_ready),
        .i_func         (func),
        .i_zone         (zone),
        .i_in_use       (in_use),
        .i_is_fixed     (is_fixed),
        .i_rsp_valid    (rsp_valid),
        .i_rsp_ready    (rsp_ready),
        .i_new_zone     (new_zone),
        .i_back_zone    (back_zone),
        .i_status       (status),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_status_count (status_count)
    );

    task automatic send_request(input logic [1:0] f, input int z, input logic use_bit,
                                input logic fix_bit);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        zone      <= z[ZONE_W-1:0];
        in_use    <= use_bit;
        is_fixed  <= fix_bit;
        do @(posedge clk); while (!(req_valid && req_ready));
        sent_count++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input int lo, input int hi, input int fill, input bit ro);
        logic [CFG_DATA_W-1:0] junk;
        drain();
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_FIRST_DATA_ZONE, {junk[16], lo[ZONE_W-1:0]});
        write_reg(CFG_ZONE_LIMIT, hi[LIMIT_W-1:0]);
        write_reg(CFG_FILL_START, {junk[15], fill[ZONE_W-1:0]});
        write_reg(CFG_READ_ONLY_MODE, {junk[16:1], ro});
        if (junk[0])
            write_reg(CFG_SPARE_IDX, junk);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    task automatic load_window(input int lo, input int hi);
        for (int z = lo; z < hi; z++)
            send_request(FUNC_LOAD, z, $urandom_range(0, 3) != 0, $urandom_range(0, 6) == 0);
    endtask

    task automatic send_random(input int lo, input int hi);
        int         pick;
        int         z;
        logic [1:0] f;
        logic [3:0] noise;
        pick = $urandom_range(0, 99);
        if (hi > lo && pick < 85)
            z = $urandom_range(lo, hi - 1);
        else if (hi > lo && pick < 92)
            z = pick[0] ? lo - 1 : hi;
        else
            z = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f = FUNC_RELOC;
        else if (pick < 65)
            f = FUNC_READ;
        else if (pick < 94)
            f = FUNC_LOAD;
        else
            f = FUNC_UNUSED;
        noise = 4'($urandom);
        if (f == FUNC_LOAD)
            send_request(f, z, noise[0] | noise[1], noise[3:1] == 3'b000);
        else
            send_request(f, z, noise[0], noise[1]);
    endtask

    task automatic run_phase(input int lo, input int hi, input int fill, input bit ro,
                             input int count, input bit stall_rsp);
        configure(lo, hi, fill, ro);
        // stall the response side while requests keep coming
        if (stall_rsp)
            hold_request = 1'b1;
        load_window(lo, hi);
        for (int k = 0; k < count; k++) begin
            // pause until every answer is back, then rewind the fill pointer
            if (k == count / 2) begin
                drain();
                write_reg(CFG_FILL_START, {1'b0, fill[ZONE_W-1:0]});
                cfg_we <= 1'b0;
            end
            send_random(lo, hi);
        end
    endtask

    initial begin : response_side
        int gap;
        bit held;
        held = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_request && !held) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int size;
        int lo;
        int hi;
        int fill;
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of fill start, first data zone and read-only mode
        write_reg(CFG_ZONE_LIMIT, 17'd16);
        cfg_we <= 1'b0;
        phase_count++;
        for (int z = 0; z < 16; z++)
            send_request(FUNC_LOAD, z, z != 5, z == 1 || z == 2 || z == 9);
        send_request(FUNC_READ,   0,     1'b0, 1'b0);
        send_request(FUNC_RELOC,  4,     1'b0, 1'b0);
        send_request(FUNC_RELOC,  9,     1'b1, 1'b1);
        send_request(FUNC_RELOC,  5,     1'b0, 1'b0);
        send_request(FUNC_READ,   3,     1'b1, 1'b0);
        send_request(FUNC_READ,   4,     1'b0, 1'b1);
        send_request(FUNC_LOAD,   16,    1'b1, 1'b1);
        send_request(FUNC_RELOC,  65535, 1'b1, 1'b1);
        send_request(FUNC_READ,   16,    1'b0, 1'b0);
        send_request(FUNC_UNUSED, 65535, 1'b1, 1'b1);

        run_phase(0,     16,    0,     1'b1, 50, 1'b0);
        run_phase(65520, 65536, 65535, 1'b0, 50, 1'b0);
        run_phase(65535, 65536, 65520, 1'b1, 40, 1'b0);
        run_phase(65535, 0,     0,     1'b0, 40, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            size = $urandom_range(8, 40);
            if ($urandom_range(0, 3) == 0)
                lo = $urandom_range(0, 64);
            else
                lo = $urandom_range(0, 65536 - size);
            hi   = lo + size;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                fill = lo;
            else if (pick < 9)
                fill = $urandom_range(lo, hi - 1);
            else
                fill = $urandom_range(0, 65535);
            quiet = (p == 3) || (p == 7);
            run_phase(lo, hi, fill, $urandom_range(0, 2) == 0, ITEMS_PER_PHASE, p == 7);
            quiet = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d requests over %0d map settings, both range ends, one empty.",
                 sent_count, phase_count);
        $display("Responses: done %0d, fixed kept %0d, out of range %0d, no destination %0d",
                 status_count[ST_DONE], status_count[ST_FIXED], status_count[ST_RANGE],
                 status_count[ST_NO_DEST]);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
